### hdl/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg
// Types and constants shared by the top-K selector files.
// ----------------------------------------------------------------------------
`default_nettype none

package tks_pkg;

  localparam int SCORE_W = 16;
  localparam int INDEX_W = 10;
  localparam int RANK_W  = 4;
  // Holds a fill count up to the largest K (16)
  localparam int FILL_W  = 5;

  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [RANK_W-1:0]  rank_t;
  typedef logic [FILL_W-1:0]  fill_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  insert;     // take in the accepted score
    logic  shift_out;  // move slot 0 to the output register, shift slots up
    logic  clear;      // empty the kept list and restart numbering
    logic  last_out;   // mark the loaded result as the final one
    rank_t rank;       // rank of the loaded result
  } tks_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    fill_t fill;       // number of kept entries
    logic  out_free;   // output register can take a new item this cycle
  } tks_status_t;

endpackage

`default_nettype wire

### hdl/tks_if.sv
// ----------------------------------------------------------------------------
// tks_if
// Valid/ready stream channels for the top-K selector: score in, result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tks_in_if;
  import tks_pkg::*;

  logic   valid;
  logic   ready;
  score_t score;
  logic   last_item;

  modport source (output valid, output score, output last_item, input ready);
  modport sink   (input valid, input score, input last_item, output ready);
endinterface

interface tks_out_if;
  import tks_pkg::*;

  logic   valid;
  logic   ready;
  rank_t  rank;
  index_t class_index;
  score_t best_score;
  logic   last_result;

  modport source (output valid, output rank, output class_index, output best_score,
                  output last_result, input ready);
  modport sink   (input valid, input rank, input class_index, input best_score,
                  input last_result, output ready);
endinterface

`default_nettype wire

### hdl/tks_datapath.sv
// ----------------------------------------------------------------------------
// tks_datapath
// Sorted slot array with parallel insertion, arrival counter and the
// registered result output.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_datapath #(
  parameter int K         = 5,
  parameter int MAX_ITEMS = 1024
) (
  input  wire                  clk,
  input  wire                  rst,
  input  tks_pkg::tks_cmd_t    cmd,
  input  tks_pkg::score_t      in_score,
  output tks_pkg::tks_status_t status,
  input  wire                  out_ready,
  output logic                 out_valid,
  output tks_pkg::rank_t       out_rank,
  output tks_pkg::index_t      out_index,
  output tks_pkg::score_t      out_score,
  output logic                 out_last
);
  import tks_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  score_t           slot_score [K];
  index_t           slot_index [K];
  fill_t            fill;
  logic [CNT_W-1:0] count;

  logic   [K-1:0]   ge;        // slot is kept and ranks ahead of the new score
  logic             take;      // insertion really happens (below the cap)
  index_t           new_index;

  // Sorted list: the slots that rank ahead form a prefix
  always_comb begin
    for (int i = 0; i < K; i++) begin
      ge[i] = (fill_t'(i) < fill) && (slot_score[i] >= in_score);
    end
  end

  assign take      = cmd.insert && (count < CNT_W'(MAX_ITEMS));
  assign new_index = index_t'(count);

  // Slot array: insert with shift down, or shift up while draining
  always_ff @(posedge clk) begin
    for (int i = 0; i < K; i++) begin
      if (take) begin
        if (!ge[i]) begin
          if (i == 0 || ge[(i == 0) ? 0 : i - 1]) begin
            slot_score[i] <= in_score;
            slot_index[i] <= new_index;
          end else begin
            slot_score[i] <= slot_score[(i == 0) ? 0 : i - 1];
            slot_index[i] <= slot_index[(i == 0) ? 0 : i - 1];
          end
        end
      end else if (cmd.shift_out && i < K - 1) begin
        slot_score[i] <= slot_score[(i < K - 1) ? i + 1 : i];
        slot_index[i] <= slot_index[(i < K - 1) ? i + 1 : i];
      end
    end
  end

  // Fill and arrival counters
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      fill  <= '0;
      count <= '0;
    end else if (take) begin
      count <= count + CNT_W'(1);
      if (fill < fill_t'(K)) begin
        fill <= fill + fill_t'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.shift_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_out) begin
      out_rank  <= cmd.rank;
      out_index <= slot_index[0];
      out_score <= slot_score[0];
      out_last  <= cmd.last_out;
    end
  end

  assign status.fill     = fill;
  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

### hdl/tks_ctrl.sv
// ----------------------------------------------------------------------------
// tks_ctrl
// Controller: accepts scores, then sequences the drain of kept entries.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  input  wire                  in_last,
  output logic                 in_ready,
  input  tks_pkg::tks_status_t status,
  output tks_pkg::tks_cmd_t    cmd
);
  import tks_pkg::*;

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic  state;
  logic  state_next;
  rank_t rank;
  rank_t rank_next;
  logic  final_one;

  assign in_ready  = (state == ST_RUN);
  assign final_one = ({1'b0, rank} == status.fill - fill_t'(1));

  // Next state and commands
  always_comb begin
    state_next    = state;
    rank_next     = rank;
    cmd.insert    = 1'b0;
    cmd.shift_out = 1'b0;
    cmd.clear     = 1'b0;
    cmd.last_out  = final_one;
    cmd.rank      = rank;
    unique case (state)
      ST_RUN: begin
        if (in_valid) begin
          cmd.insert = 1'b1;
          if (in_last) begin
            state_next = ST_DRAIN;
            rank_next  = '0;
          end
        end
      end
      ST_DRAIN: begin
        if (status.fill == '0) begin
          cmd.clear  = 1'b1;
          state_next = ST_RUN;
        end else if (status.out_free) begin
          cmd.shift_out = 1'b1;
          rank_next     = rank + rank_t'(1);
          if (final_one) begin
            cmd.clear  = 1'b1;
            state_next = ST_RUN;
          end
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      rank  <= '0;
    end else begin
      state <= state_next;
      rank  <= rank_next;
    end
  end

endmodule

`default_nettype wire

### hdl/top_k_selector.sv
// ----------------------------------------------------------------------------
// top_k_selector
// Streaming top-K selection: keeps the K highest scores with their arrival
// indices and emits them best first when the last item of a stream arrives.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                        
//  scores   in   score[15:0], last_item                         
//  results  out  rank[3:0], class_index[9:0], best_score[15:0],
//                last_result                                    
//
//  A score is taken every cycle while the stream runs; insertion compares
//  all K slots at once. After the last item, the drain moves one result per
//  cycle through the output register while the results channel accepts,
//  with input held off meanwhile. The next stream may start while the final
//  result waits. Stalls on the result side pause the drain. Synchronous
//  reset empties the kept list and the output register at once.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_selector #(
  parameter int K         = 5,
  parameter int MAX_ITEMS = 1024
) (
  input wire clk,
  input wire rst,
  tks_in_if.sink    scores,
  tks_out_if.source results
);
  import tks_pkg::*;

  tks_cmd_t    cmd;
  tks_status_t status;

  tks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (scores.valid),
    .in_last  (scores.last_item),
    .in_ready (scores.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tks_datapath #(
    .K         (K),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_score  (scores.score),
    .status    (status),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .out_rank  (results.rank),
    .out_index (results.class_index),
    .out_score (results.best_score),
    .out_last  (results.last_result)
  );

endmodule

`default_nettype wire
